FILE: rtl/windowed_intensity_gain_offset_assert.svh
// ----------------------------------------------------------------------------
// windowed intensity gain offset assertion macros
// shared assertion forms for the gain/offset estimator
// ----------------------------------------------------------------------------
`ifndef WINDOWED_INTENSITY_GAIN_OFFSET_ASSERT_SVH
`define WINDOWED_INTENSITY_GAIN_OFFSET_ASSERT_SVH

// same-cycle implication
`define WIGO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WIGO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wigo_pkg.sv
// ----------------------------------------------------------------------------
// wigo_pkg
// shared types and constants of the windowed intensity gain offset block
// ----------------------------------------------------------------------------
`default_nettype none

package wigo_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int LOG_D        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int IDX_W        = LOG_D;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int BSUM_W       = 17 + LOG_D;
    localparam int ASUM_W       = 16 + LOG_D;

    localparam int DVD_W = 33;
    localparam int DVS_W = 17;
    localparam int DCNT_W = $clog2(DVD_W + 1);

    localparam logic [16:0] ALPHA_MIN = 17'd65536;
    localparam logic [16:0] ALPHA_MAX = 17'd91750;
    localparam logic [16:0] BETA_MAX  = 17'd65536;

    typedef struct packed {
        logic [3:0][15:0] amb;
        logic [16:0]      ov;
        logic [16:0]      bg;
    } sample_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
    } win_stat_t;

    typedef struct packed {
        logic             done;
        logic             busy;
    } div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_DIV,
        ST_WAIT,
        ST_MUL,
        ST_BETA,
        ST_OUT
    } state_t;

    // divide jobs, run in this order
    localparam logic [2:0] JOB_BG    = 3'd0;
    localparam logic [2:0] JOB_OV    = 3'd1;
    localparam logic [2:0] JOB_AMB0  = 3'd2;
    localparam logic [2:0] JOB_AMB1  = 3'd3;
    localparam logic [2:0] JOB_AMB2  = 3'd4;
    localparam logic [2:0] JOB_AMB3  = 3'd5;
    localparam logic [2:0] JOB_ALPHA = 3'd6;

endpackage

`default_nettype wire

FILE: rtl/wigo_window.sv
// ----------------------------------------------------------------------------
// wigo_window
// sample ring memory with running sums and sample count
// ----------------------------------------------------------------------------
`default_nettype none

module wigo_window
    import wigo_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              add,
    input  wire logic              clear,
    input  wire sample_t           sample,
    input  wire logic [4:0]        limit,
    output win_stat_t              stat,
    output logic [BSUM_W-1:0]      bg_sum,
    output logic [BSUM_W-1:0]      ov_sum,
    output logic [3:0][ASUM_W-1:0] amb_sum
);

    sample_t mem [WINDOW_DEPTH];

    logic [IDX_W-1:0]       newest_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [BSUM_W-1:0]      bg_sum_reg;
    logic [BSUM_W-1:0]      ov_sum_reg;
    logic [3:0][ASUM_W-1:0] amb_sum_reg;
    logic                   phase_reg;
    logic                   drop_reg;
    logic [IDX_W-1:0]       slot_reg;
    sample_t                pend_reg;
    sample_t                rd_reg;

    logic [CNT_W+4:0] lim_w;
    logic [CNT_W+4:0] eff_lim;
    logic             drop;
    logic [IDX_W+1:0] old_w;
    logic [IDX_W-1:0] old_idx;
    logic [IDX_W:0]   slot_w;
    logic [IDX_W-1:0] slot;

    always_comb
    begin
        lim_w = {{CNT_W{1'b0}}, limit};
        if (lim_w == '0)
            eff_lim = (CNT_W+5)'(1);
        else if (lim_w > (CNT_W+5)'(WINDOW_DEPTH))
            eff_lim = (CNT_W+5)'(WINDOW_DEPTH);
        else
            eff_lim = lim_w;
        drop = {5'b0, count_reg} >= eff_lim;
        // oldest slot, count is at least one when dropping
        old_w = (IDX_W+2)'(newest_reg) + (IDX_W+2)'(WINDOW_DEPTH) + 1'b1
              - (IDX_W+2)'(count_reg);
        if (old_w >= (IDX_W+2)'(2*WINDOW_DEPTH))
            old_w = old_w - (IDX_W+2)'(2*WINDOW_DEPTH);
        else if (old_w >= (IDX_W+2)'(WINDOW_DEPTH))
            old_w = old_w - (IDX_W+2)'(WINDOW_DEPTH);
        old_idx = old_w[IDX_W-1:0];
        slot_w = (IDX_W+1)'(newest_reg) + 1'b1;
        if (slot_w >= (IDX_W+1)'(WINDOW_DEPTH))
            slot_w = '0;
        slot = slot_w[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (add)
            rd_reg <= mem[old_idx];
        if (phase_reg)
            mem[slot_reg] <= pend_reg;
    end

    always_ff @(posedge clk)
    begin
        if (add)
        begin
            pend_reg <= sample;
            slot_reg <= slot;
            drop_reg <= drop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg  <= '0;
            count_reg   <= '0;
            bg_sum_reg  <= '0;
            ov_sum_reg  <= '0;
            amb_sum_reg <= '0;
            phase_reg   <= 1'b0;
        end
        else if (clear)
        begin
            newest_reg  <= '0;
            count_reg   <= '0;
            bg_sum_reg  <= '0;
            ov_sum_reg  <= '0;
            amb_sum_reg <= '0;
            phase_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= add;
            if (add && !drop)
                count_reg <= count_reg + 1'b1;
            if (phase_reg)
            begin
                newest_reg <= slot_reg;
                bg_sum_reg <= bg_sum_reg + BSUM_W'(pend_reg.bg)
                            - (drop_reg ? BSUM_W'(rd_reg.bg) : '0);
                ov_sum_reg <= ov_sum_reg + BSUM_W'(pend_reg.ov)
                            - (drop_reg ? BSUM_W'(rd_reg.ov) : '0);
                for (int k = 0; k < 4; k++)
                    amb_sum_reg[k] <= amb_sum_reg[k] + ASUM_W'(pend_reg.amb[k])
                                    - (drop_reg ? ASUM_W'(rd_reg.amb[k]) : '0);
            end
        end
    end

    assign stat.done  = phase_reg;
    assign stat.count = count_reg;
    assign bg_sum     = bg_sum_reg;
    assign ov_sum     = ov_sum_reg;
    assign amb_sum    = amb_sum_reg;

endmodule

`default_nettype wire

FILE: rtl/wigo_divider.sv
// ----------------------------------------------------------------------------
// wigo_divider
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wigo_divider
    import wigo_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output div_stat_t             stat,
    output logic [DVD_W-1:0]      quotient
);

    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    rem_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVS_W:0] trial;
    logic           fits;

    always_comb
    begin
        trial = {rem_reg[DVS_W-1:0], dvd_reg[DVD_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            // quotient bits enter at the bottom as dividend bits leave the top
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? trial - {1'b0, dvs_reg} : trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= DCNT_W'(DVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.busy = busy_reg;
    assign quotient  = dvd_reg;

endmodule

`default_nettype wire

FILE: rtl/windowed_intensity_gain_offset.sv
// an add transfer passes through the window update, 7 serial divides, multiply,
// offset and output load before its result shows on m_tvalid
// the block takes no new transfer until that result is loaded into the output register,
// and waits longer while the output register holds a result the receiver has not taken
// a clear transfer empties the window and gives no result
// reset: rst_n asynchronous, active low, empties the window; ring contents stay undefined
// ----------------------------------------------------------------------------
// windowed_intensity_gain_offset
// moving-average window with gain and offset estimate
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_intensity_gain_offset
    import wigo_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // bg_intensity, overlay_intensity, ambient_0..3, window_limit, zero fill
    input  wire logic [103:0] s_tdata,
    // operation
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // mean_background, mean_overlay, mean_ambient_0..3, gain_alpha,
    // offset_beta, samples_held, zero fill
    output logic [143:0]      m_tdata
);

    state_t state_reg;
    state_t state_next;

    logic [2:0]       job_reg;
    logic [16:0]      mbg_reg;
    logic [16:0]      mov_reg;
    logic [3:0][15:0] mamb_reg;
    logic [16:0]      alpha_reg;
    logic [33:0]      prod_reg;
    logic [16:0]      beta_reg;
    logic [CNT_W-1:0] held_reg;
    logic             out_valid_reg;
    logic [143:0]     out_reg;

    logic                   accept;
    logic                   win_add;
    logic                   win_clear;
    logic                   div_start;
    logic                   out_load;
    sample_t                sample;
    win_stat_t              win_stat;
    div_stat_t              div_stat;
    logic [BSUM_W-1:0]      bg_sum;
    logic [BSUM_W-1:0]      ov_sum;
    logic [3:0][ASUM_W-1:0] amb_sum;
    logic [DVD_W-1:0]       dividend;
    logic [DVS_W-1:0]       divisor;
    logic [DVD_W-1:0]       quotient;
    logic [18:0]            diff;

    assign sample.bg  = s_tdata[16:0];
    assign sample.ov  = s_tdata[33:17];
    assign sample.amb = s_tdata[97:34];

    assign s_tready  = state_reg == ST_IDLE;
    assign accept    = s_tvalid && s_tready;
    assign win_add   = accept && !s_tuser;
    assign win_clear = accept && s_tuser;

    wigo_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .add     (win_add),
        .clear   (win_clear),
        .sample  (sample),
        .limit   (s_tdata[102:98]),
        .stat    (win_stat),
        .bg_sum  (bg_sum),
        .ov_sum  (ov_sum),
        .amb_sum (amb_sum)
    );

    always_comb
    begin
        divisor = DVS_W'(win_stat.count);
        case (job_reg)
            JOB_BG:   dividend = DVD_W'(bg_sum);
            JOB_OV:   dividend = DVD_W'(ov_sum);
            JOB_AMB0: dividend = DVD_W'(amb_sum[0]);
            JOB_AMB1: dividend = DVD_W'(amb_sum[1]);
            JOB_AMB2: dividend = DVD_W'(amb_sum[2]);
            JOB_AMB3: dividend = DVD_W'(amb_sum[3]);
            default:
            begin
                // a zero overlay mean yields all ones, clamped to the top
                dividend = {mbg_reg, 16'b0};
                divisor  = mov_reg;
            end
        endcase
    end

    wigo_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (win_add)
                    state_next = ST_WIN;
            ST_WIN:
                if (win_stat.done)
                    state_next = ST_DIV;
            ST_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
                if (div_stat.done)
                    state_next = (job_reg == JOB_ALPHA) ? ST_MUL : ST_DIV;
            ST_MUL:
                state_next = ST_BETA;
            ST_BETA:
                state_next = ST_OUT;
            ST_OUT:
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_BG;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_WIN)
                job_reg <= JOB_BG;
            else if (state_reg == ST_WAIT && div_stat.done)
                job_reg <= job_reg + 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign diff = {2'b0, mbg_reg} - {1'b0, prod_reg[33:16]};

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WIN)
            held_reg <= win_stat.count;
        if (state_reg == ST_WAIT && div_stat.done)
        begin
            case (job_reg)
                JOB_BG:   mbg_reg     <= quotient[16:0];
                JOB_OV:   mov_reg     <= quotient[16:0];
                JOB_AMB0: mamb_reg[0] <= quotient[15:0];
                JOB_AMB1: mamb_reg[1] <= quotient[15:0];
                JOB_AMB2: mamb_reg[2] <= quotient[15:0];
                JOB_AMB3: mamb_reg[3] <= quotient[15:0];
                default:
                    if (quotient < DVD_W'(ALPHA_MIN))
                        alpha_reg <= ALPHA_MIN;
                    else if (quotient > DVD_W'(ALPHA_MAX))
                        alpha_reg <= ALPHA_MAX;
                    else
                        alpha_reg <= quotient[16:0];
            endcase
        end
        if (state_reg == ST_MUL)
            prod_reg <= alpha_reg * mov_reg;
        if (state_reg == ST_BETA)
        begin
            if (diff[18])
                beta_reg <= '0;
            else if (diff[17:0] > {1'b0, BETA_MAX})
                beta_reg <= BETA_MAX;
            else
                beta_reg <= diff[16:0];
        end
        if (out_load)
            out_reg <= {7'b0, 5'(held_reg), beta_reg, alpha_reg, mamb_reg, mov_reg, mbg_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    `include "windowed_intensity_gain_offset_assert.svh"

    `WIGO_ASSERT_NOW(a_held_nonzero, m_tvalid, m_tdata[136:132] != 5'd0, "empty window reported")
    `WIGO_ASSERT_NOW(a_alpha_range, m_tvalid,
        m_tdata[114:98] >= ALPHA_MIN && m_tdata[114:98] <= ALPHA_MAX, "alpha out of range")
    `WIGO_ASSERT_NOW(a_div_idle, div_start, !div_stat.busy, "divider restarted while busy")
    `WIGO_ASSERT_NEXT(a_win_done, win_add, win_stat.done, "window update did not finish")

endmodule

`default_nettype wire
